FILE: sv/et_pkg.sv
// Shared types, codes and character tables for the expression tokenizer.
package et_pkg;

  // Positions and lengths saturate at this limit (never above 65535).
  localparam longint unsigned MAX_TEXT_LEN = 65535;
  localparam logic [15:0] POS_LIMIT =
    (MAX_TEXT_LEN > 65535) ? 16'hFFFF : 16'(MAX_TEXT_LEN);

  typedef enum logic [2:0] {
    K_OP    = 3'd0,
    K_NUM   = 3'd1,
    K_NAME  = 3'd2,
    K_BLANK = 3'd3,
    K_NONE  = 3'd4,
    K_BAD   = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    OPK_OPEN   = 3'd0,
    OPK_CLOSE  = 3'd1,
    OPK_COMMA  = 3'd2,
    OPK_PLUS   = 3'd3,
    OPK_MINUS  = 3'd4,
    OPK_TIMES  = 3'd5,
    OPK_DIVIDE = 3'd6,
    OPK_NONE   = 3'd7
  } opk_t;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_UNDEF     = 3'd1,
    ERR_NAME_NUM  = 3'd2,
    ERR_UNBAL     = 3'd3,
    ERR_TOO_DEEP  = 3'd4
  } err_t;

  typedef struct packed {
    logic [1:0]        token_kind;
    logic [15:0]       start_index;
    logic [15:0]       token_length;
    opk_t              operator_kind;
    logic signed [7:0] nest_level;
    err_t              error_code;
    logic              end_of_text;
  } res_t;

  // Results raised by one accepted character, in delivery order.
  typedef struct packed {
    logic close_v;
    res_t close_res;
    logic final_v;
    res_t final_res;
  } ev_t;

  function automatic kind_t classify(logic [7:0] c);
    kind_t k;
    k = K_BAD;
    unique case (c)
      "(", ")", "{", "}", "[", "]", ",", "+", "-", "*", "/": k = K_OP;
      " ", 8'h09:                                            k = K_BLANK;
      ".":                                                   k = K_NUM;
      "_":                                                   k = K_NAME;
      default: begin
        if (c >= "0" && c <= "9") begin
          k = K_NUM;
        end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
          k = K_NAME;
        end
      end
    endcase
    return k;
  endfunction

  function automatic opk_t op_kind(logic [7:0] c);
    opk_t o;
    unique case (c)
      "(", "{", "[": o = OPK_OPEN;
      ")", "}", "]": o = OPK_CLOSE;
      ",":           o = OPK_COMMA;
      "+":           o = OPK_PLUS;
      "-":           o = OPK_MINUS;
      "*":           o = OPK_TIMES;
      "/":           o = OPK_DIVIDE;
      default:       o = OPK_NONE;
    endcase
    return o;
  endfunction

endpackage

FILE: sv/et_lexer.sv
// Lexer core: token state, boundary decision and result formation per character.
module et_lexer #(
  parameter int MAX_DEPTH = 127
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         take,
  input  logic [7:0]   ch,
  input  logic         last,
  output et_pkg::ev_t  ev
);
  import et_pkg::*;

  localparam int DW = $clog2(MAX_DEPTH + 1) + 1;
  localparam logic signed [DW-1:0] DMAX = DW'(MAX_DEPTH);
  localparam logic signed [DW-1:0] DMIN = -DMAX;
  localparam logic signed [DW-1:0] DONE = DW'(1);

  typedef struct packed {
    res_t                  res;
    logic signed [DW-1:0]  depth;
  } emit_t;

  function automatic emit_t do_emit(kind_t k, logic [15:0] st, logic [15:0] len,
                                    opk_t opk, logic signed [DW-1:0] d, logic fin);
    emit_t                e;
    logic signed [DW-1:0] lv;
    err_t                 er;
    er      = ERR_OK;
    lv      = d;
    e.depth = d;
    if (opk == OPK_OPEN) begin
      if (d >= DMAX) er = ERR_TOO_DEEP;
      else           e.depth = d + DONE;
    end else if (opk == OPK_CLOSE) begin
      if (d <= DMIN) er = ERR_TOO_DEEP;
      else           e.depth = d - DONE;
      lv = e.depth;
    end
    if (fin && e.depth != '0) er = ERR_UNBAL;
    e.res.token_kind    = k[1:0];
    e.res.start_index   = st;
    e.res.token_length  = len;
    e.res.operator_kind = opk;
    e.res.nest_level    = 8'(lv);
    e.res.error_code    = er;
    e.res.end_of_text   = fin;
    return e;
  endfunction

  kind_t                cur_kind_r, cur_kind_nxt;
  logic [15:0]          cur_start_r, cur_start_nxt;
  logic [15:0]          cur_len_r, cur_len_nxt;
  opk_t                 cur_opk_r, cur_opk_nxt;
  logic [15:0]          pos_r, pos_nxt;
  logic signed [DW-1:0] depth_r, depth_nxt;
  logic                 err_seen_r, err_seen_nxt;

  kind_t                cls;
  opk_t                 opk_new;
  logic                 bad;
  logic                 cont;
  err_t                 bad_code;
  emit_t                em_close, em_final;
  logic signed [DW-1:0] depth_mid;
  logic [15:0]          len_inc;
  res_t                 err_res;

  always_comb begin
    cls      = classify(ch);
    opk_new  = (cls == K_OP) ? op_kind(ch) : OPK_NONE;
    bad_code = (cls == K_BAD) ? ERR_UNDEF : ERR_NAME_NUM;
    bad      = (cls == K_BAD) || (cur_kind_r == K_NUM && cls == K_NAME);
    cont     = (cur_kind_r == K_NAME && (cls == K_NAME || cls == K_NUM)) ||
               (cur_kind_r == K_NUM && cls == K_NUM);
    len_inc  = (cur_len_r < POS_LIMIT) ? cur_len_r + 16'd1 : cur_len_r;

    // Token closed by this character
    em_close  = do_emit(cur_kind_r, cur_start_r, cur_len_r, cur_opk_r, depth_r, 1'b0);
    depth_mid = (cont || cur_kind_r == K_NONE) ? depth_r : em_close.depth;

    // Token still open after this character, flushed on the final one
    if (cont) begin
      em_final = do_emit(cur_kind_r, cur_start_r, len_inc, cur_opk_r, depth_mid, 1'b1);
    end else begin
      em_final = do_emit(cls, pos_r, 16'd1, opk_new, depth_mid, 1'b1);
    end

    err_res.token_kind    = 2'(K_OP);
    err_res.start_index   = pos_r;
    err_res.token_length  = '0;
    err_res.operator_kind = OPK_NONE;
    err_res.nest_level    = 8'(depth_r);
    err_res.error_code    = bad_code;
    err_res.end_of_text   = last;

    ev.close_v   = take && !err_seen_r && (bad || (!cont && cur_kind_r != K_NONE));
    ev.close_res = bad ? err_res : em_close.res;
    ev.final_v   = take && !err_seen_r && !bad && last;
    ev.final_res = em_final.res;
  end

  always_comb begin
    cur_kind_nxt  = cur_kind_r;
    cur_start_nxt = cur_start_r;
    cur_len_nxt   = cur_len_r;
    cur_opk_nxt   = cur_opk_r;
    pos_nxt       = pos_r;
    depth_nxt     = depth_r;
    err_seen_nxt  = err_seen_r;
    if (take) begin
      if (err_seen_r) begin
        // Drop everything up to the final character, then start afresh
        if (last) begin
          err_seen_nxt = 1'b0;
          cur_kind_nxt = K_NONE;
          pos_nxt      = '0;
          depth_nxt    = '0;
        end
      end else if (bad) begin
        err_seen_nxt = !last;
        if (last) begin
          cur_kind_nxt = K_NONE;
          pos_nxt      = '0;
          depth_nxt    = '0;
        end
      end else if (last) begin
        cur_kind_nxt = K_NONE;
        pos_nxt      = '0;
        depth_nxt    = '0;
      end else begin
        if (cont) begin
          cur_len_nxt = len_inc;
        end else begin
          cur_kind_nxt  = cls;
          cur_start_nxt = pos_r;
          cur_len_nxt   = 16'd1;
          cur_opk_nxt   = opk_new;
        end
        pos_nxt   = (pos_r < POS_LIMIT) ? pos_r + 16'd1 : pos_r;
        depth_nxt = depth_mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_kind_r <= K_NONE;
      pos_r      <= '0;
      depth_r    <= '0;
      err_seen_r <= 1'b0;
    end else begin
      cur_kind_r <= cur_kind_nxt;
      pos_r      <= pos_nxt;
      depth_r    <= depth_nxt;
      err_seen_r <= err_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_start_r <= cur_start_nxt;
    cur_len_r   <= cur_len_nxt;
    cur_opk_r   <= cur_opk_nxt;
  end

endmodule

FILE: sv/et_out_queue.sv
// Four-entry result queue: takes up to two results a cycle, delivers one while out_ready is high.
module et_out_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  et_pkg::ev_t  ev,
  output logic         room,
  output logic         out_valid,
  input  logic         out_ready,
  output et_pkg::res_t out_res
);
  import et_pkg::*;

  res_t       q_r [4];
  res_t       q_nxt [4];
  res_t       q_sh [4];
  logic [2:0] cnt_r, cnt_nxt;
  logic [2:0] c1, c2;
  logic       pop;

  assign out_valid = (cnt_r != 3'd0);
  assign out_res   = q_r[0];
  assign room      = (cnt_r <= 3'd2);
  assign pop       = out_valid && out_ready;

  always_comb begin
    if (pop) begin
      q_sh[0] = q_r[1];
      q_sh[1] = q_r[2];
      q_sh[2] = q_r[3];
      q_sh[3] = q_r[3];
    end else begin
      q_sh[0] = q_r[0];
      q_sh[1] = q_r[1];
      q_sh[2] = q_r[2];
      q_sh[3] = q_r[3];
    end
    c1 = cnt_r - {2'b00, pop};
    c2 = c1 + {2'b00, ev.close_v};
    for (int i = 0; i < 4; i++) begin
      q_nxt[i] = q_sh[i];
      if (ev.close_v && c1 == 3'(i)) q_nxt[i] = ev.close_res;
      if (ev.final_v && c2 == 3'(i)) q_nxt[i] = ev.final_res;
    end
    cnt_nxt = c2 + {2'b00, ev.final_v};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) q_r[i] <= q_nxt[i];
  end

endmodule

FILE: sv/expression_tokenizer.sv
// Output: a result reaches the output in the cycle after its character beat when the queue
// is empty; the second result of a final character follows it out of the queue.
// Throughput: one character per cycle, back to back while in_tready is high; results drain
// one per cycle from a four-entry queue behind the lexer while out_tready is high; in_tready
// is high while it holds at most two results, so it never depends on the output side in the same cycle.
// Reset: synchronous, active low; clears token state, depth and the queue.
module expression_tokenizer #(
  parameter int MAX_DEPTH = 127
) (
  input  logic        clk,
  input  logic        rst_n,
  // Character stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,   // is_last
  // Token stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] start_index, [31:16] token_length,
                                  // [34:32] operator_kind, [42:35] nest_level,
                                  // [45:43] error_code, [47:46] zero
  output logic [1:0]  out_tuser,  // [1:0] token_kind
  output logic        out_tlast   // end_of_text
);
  import et_pkg::*;

  ev_t  ev;
  res_t head;
  logic take;

  // Take a character beat only while the queue can absorb two results
  assign take = in_tvalid && in_tready;

  // Classify the character, decide the token boundary, update depth and form
  // the closed and final token results in one pass
  et_lexer #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_lexer (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .ch    (in_tdata),
    .last  (in_tlast),
    .ev    (ev)
  );

  // Hold results in order until the sink takes each beat
  et_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev        (ev),
    .room      (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (head)
  );

  // Pack the head result onto the output beat
  assign out_tdata = {2'b00, head.error_code, head.nest_level, head.operator_kind,
                      head.token_length, head.start_index};
  assign out_tuser = head.token_kind;
  assign out_tlast = head.end_of_text;

endmodule

FILE: sv/et_checker.sv
// Port-level checks for the expression tokenizer and their binding.
module et_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import et_pkg::*;

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // Nothing is offered straight after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // Only operator tokens carry an operator kind
  a_opk: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != 2'(K_OP) |-> out_tdata[34:32] == OPK_NONE)
    else $error("non-operator token with operator kind");

  // Character errors report no length
  a_errlen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[45:43] == ERR_UNDEF || out_tdata[45:43] == ERR_NAME_NUM)
    |-> out_tdata[31:16] == 16'd0)
    else $error("error result with non-zero length");

  // Unbalanced is only reported at the end of the text
  a_unbal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[45:43] == ERR_UNBAL |-> out_tlast)
    else $error("unbalanced reported before end of text");

endmodule

bind expression_tokenizer et_checker u_et_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
